>>> rtl/mbs_pkg.sv
// Package for the masked boxcar smoother: shared constants, register indexes
// and controller states. No dependencies.
package mbs_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int MAX_WINDOW_DEF    = 31;
    localparam int MAX_SERIES_DEF    = 4096;
    localparam int CFG_DATA_W        = 13;
    localparam int CFG_INDEX_W       = 2;
    localparam int WINDOW_W          = 5;
    localparam int SERIES_W          = 13;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 5'd5;
    localparam logic [SERIES_W-1:0] SERIES_RST = 13'd365;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_RAMP   = 2'd1,
        CFG_SERIES = 2'd2,
        CFG_HONOR  = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

endpackage

>>> rtl/mbs_cell.sv
// One storage cell of the sample ring: shifts in a new sample or rotates
// towards the read head. Depends on mbs_pkg.
module mbs_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         rot,
    input  logic [mbs_pkg::SAMPLE_W-1:0] shift_in,
    input  logic [mbs_pkg::SAMPLE_W-1:0] rot_in,
    output logic [mbs_pkg::SAMPLE_W-1:0] q
);
    logic [mbs_pkg::SAMPLE_W-1:0] val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (load) begin
            val_reg <= shift_in;
        end else if (rot) begin
            val_reg <= rot_in;
        end
    end

    assign q = val_reg;
endmodule

>>> rtl/mbs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module mbs_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    always_comb begin
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = quo_next;
endmodule

>>> rtl/masked_boxcar_smoother_core.sv
// Masked boxcar / triangular smoother, one sample in, results out in order.
// Per non-error result: a scan of all MAX_WINDOW ring cells, a divide of the SAMPLE_W plus
// weight-sum width total (skipped if nothing is included) and one output transfer.
// A new sample is taken only once all results of the last one are out, so output stalls hold the input.
// The final sample of a series gives up to tail+1 results back to back.
// aresetn (synchronous) clears control, sample counters and cells and loads the config registers' defaults.
module masked_boxcar_smoother_core #(
    parameter int MAX_WINDOW        = mbs_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SERIES_LENGTH = mbs_pkg::MAX_SERIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // sample
    input  logic                            s_tuser,   // sample_good
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // smoothed
    output logic                            m_tuser,   // status
    output logic                            m_tlast,   // last_of_series
    input  logic                            cfg_wr_en,
    input  logic [mbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    localparam int SW    = mbs_pkg::SAMPLE_W;
    localparam int CW    = $clog2(MAX_SERIES_LENGTH + 1);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int WT_W  = $clog2(MAX_WINDOW / 2 + 2);
    localparam int WS_W  = $clog2((MAX_WINDOW / 2 + 1) * (MAX_WINDOW / 2 + 1) + 1);
    localparam int TOT_W = SW + WS_W;
    localparam int DW    = ((CW > AW) ? CW : AW) + 2;

    // configuration registers
    logic [mbs_pkg::WINDOW_W-1:0] win_reg;
    logic                         ramp_cfg_reg;
    logic [mbs_pkg::SERIES_W-1:0] series_reg;
    logic                         honor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= mbs_pkg::WINDOW_RST;
            ramp_cfg_reg <= 1'b0;
            series_reg   <= mbs_pkg::SERIES_RST;
            honor_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (mbs_pkg::cfg_index_t'(cfg_index))
                mbs_pkg::CFG_WINDOW: win_reg      <= cfg_wdata[mbs_pkg::WINDOW_W-1:0];
                mbs_pkg::CFG_RAMP:   ramp_cfg_reg <= cfg_wdata[0];
                mbs_pkg::CFG_SERIES: series_reg   <= cfg_wdata;
                mbs_pkg::CFG_HONOR:  honor_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // settings derived from the registers at the first sample of a series
    int          n_int, w_int;
    logic [CW-1:0] fresh_n;
    logic [WW-1:0] fresh_tail;
    logic          fresh_err;

    always_comb begin
        n_int = int'(series_reg);
        if (n_int == 0) n_int = 1;
        if (n_int > MAX_SERIES_LENGTH) n_int = MAX_SERIES_LENGTH;
        fresh_err = int'(win_reg) > (n_int >> 1);
        w_int = int'(win_reg);
        if (w_int[0] == 1'b0) w_int = w_int + 1;
        if (w_int > MAX_WINDOW) begin
            w_int = MAX_WINDOW;
            if (w_int[0] == 1'b0) w_int = w_int - 1;
        end
        fresh_n    = CW'(n_int);
        fresh_tail = WW'(w_int >> 1);
    end

    mbs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] rcv_reg, rcv_next, emit_reg, emit_next;
    logic [CW-1:0] k_reg, k_next, pos_reg, pos_next, n_reg, n_next;
    logic [WW-1:0] tail_reg, tail_next;
    logic          ramp_reg, ramp_next, err_reg, err_next, final_reg, final_next;
    logic [AW-1:0] age_reg, age_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [WS_W-1:0]  wsum_reg, wsum_next;
    logic [SW-1:0]    res_reg, res_next;
    logic             last_reg, last_next, status_reg, status_next;

    logic          in_xfer, out_xfer, first, cur_final;
    logic [CW-1:0] cur_n, rcv_inc, emit_inc;
    logic [SW-1:0] store_val, head;
    logic          div_start, div_done;
    logic [TOT_W-1:0] div_q;

    // sample ring: cell 0 is the newest sample and the read head
    logic [SW-1:0] cell_q [MAX_WINDOW];
    logic          ring_load, ring_rot;

    assign store_val = (s_tuser || !honor_reg) ? s_tdata : '0;
    assign ring_load = in_xfer;
    assign ring_rot  = (state_reg == mbs_pkg::S_SCAN);

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_ring
        mbs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (ring_load),
            .rot      (ring_rot),
            .shift_in ((g == 0) ? store_val : cell_q[(g == 0) ? 0 : g - 1]),
            .rot_in   (cell_q[(g + 1) % MAX_WINDOW]),
            .q        (cell_q[g])
        );
    end
    assign head = cell_q[0];

    // contribution of the sample at the head (age age_reg)
    logic signed [DW-1:0] offs, offs_abs;
    logic                 in_win;
    logic [WT_W-1:0]      wt;

    always_comb begin
        offs     = $signed(DW'(k_reg)) - $signed(DW'(age_reg)) - $signed(DW'(pos_reg));
        offs_abs = (offs < 0) ? -offs : offs;
        in_win   = (DW'(age_reg) <= DW'(k_reg)) && (offs_abs <= $signed(DW'(tail_reg)))
                   && (head != '0);
        wt       = ramp_reg ? WT_W'(DW'(tail_reg) + DW'(1) - offs_abs) : WT_W'(1);
    end

    mbs_div #(.NUM_W(TOT_W), .DEN_W(WS_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (wsum_next),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign first    = (rcv_reg == '0);
    assign cur_n    = first ? fresh_n : n_reg;
    assign rcv_inc  = rcv_reg + 1'b1;
    assign emit_inc = emit_reg + 1'b1;
    assign cur_final = rcv_inc >= cur_n;
    assign div_start = (state_reg == mbs_pkg::S_SCAN) && (age_reg == AW'(MAX_WINDOW - 1))
                       && (wsum_next != '0);

    always_comb begin
        state_next  = state_reg;
        rcv_next    = rcv_reg;
        emit_next   = emit_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        tail_next   = tail_reg;
        ramp_next   = ramp_reg;
        err_next    = err_reg;
        final_next  = final_reg;
        age_next    = age_reg;
        total_next  = total_reg;
        wsum_next   = wsum_reg;
        res_next    = res_reg;
        last_next   = last_reg;
        status_next = status_reg;

        unique case (state_reg)
            mbs_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (first) begin
                        n_next    = fresh_n;
                        tail_next = fresh_tail;
                        ramp_next = ramp_cfg_reg;
                        err_next  = fresh_err;
                    end
                    k_next     = rcv_reg;
                    final_next = cur_final;
                    rcv_next   = cur_final ? '0 : rcv_inc;
                    state_next = mbs_pkg::S_DECIDE;
                end
            end
            mbs_pkg::S_DECIDE: begin
                state_next = mbs_pkg::S_IDLE;
                if (err_reg) begin
                    if (final_reg) begin
                        res_next    = '0;
                        status_next = 1'b1;
                        last_next   = 1'b1;
                        emit_next   = '0;
                        state_next  = mbs_pkg::S_OUT;
                    end
                end else if (final_reg || (k_reg >= CW'(tail_reg))) begin
                    pos_next   = emit_reg;
                    age_next   = '0;
                    total_next = '0;
                    wsum_next  = '0;
                    state_next = mbs_pkg::S_SCAN;
                end
            end
            mbs_pkg::S_SCAN: begin
                if (in_win) begin
                    total_next = total_reg + TOT_W'(head * wt);
                    wsum_next  = wsum_reg + WS_W'(wt);
                end
                age_next = age_reg + 1'b1;
                if (age_reg == AW'(MAX_WINDOW - 1)) begin
                    status_next = 1'b0;
                    last_next   = (pos_reg == n_reg - 1'b1);
                    if (wsum_next == '0) begin
                        res_next   = '0;
                        state_next = mbs_pkg::S_OUT;
                    end else begin
                        state_next = mbs_pkg::S_DIV;
                    end
                end
            end
            mbs_pkg::S_DIV: begin
                if (div_done) begin
                    res_next   = div_q[SW-1:0];
                    state_next = mbs_pkg::S_OUT;
                end
            end
            mbs_pkg::S_OUT: begin
                if (out_xfer) begin
                    state_next = mbs_pkg::S_IDLE;
                    if (!err_reg) begin
                        emit_next = emit_inc;
                        if (final_reg) begin
                            if (emit_inc < n_reg) begin
                                pos_next   = emit_inc;
                                age_next   = '0;
                                total_next = '0;
                                wsum_next  = '0;
                                state_next = mbs_pkg::S_SCAN;
                            end else begin
                                emit_next = '0;
                            end
                        end
                    end
                end
            end
            default: state_next = mbs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbs_pkg::S_IDLE;
            rcv_reg   <= '0;
            emit_reg  <= '0;
            n_reg     <= CW'(1);
            tail_reg  <= '0;
            ramp_reg  <= 1'b0;
            err_reg   <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rcv_reg   <= rcv_next;
            emit_reg  <= emit_next;
            n_reg     <= n_next;
            tail_reg  <= tail_next;
            ramp_reg  <= ramp_next;
            err_reg   <= err_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        age_reg    <= age_next;
        total_reg  <= total_next;
        wsum_reg   <= wsum_next;
        res_reg    <= res_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign s_tready = (state_reg == mbs_pkg::S_IDLE);
    assign m_tvalid = (state_reg == mbs_pkg::S_OUT);
    assign m_tdata  = res_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
endmodule

>>> test/tb_masked_boxcar_smoother_core.sv
// Testbench for masked_boxcar_smoother_core: directed table then random series,
// every result checked against table values or an in-bench smoother model, with random idling.
// Depends on rtl/mbs_pkg.sv and rtl/masked_boxcar_smoother_core.sv.
`timescale 1ns / 1ps

module tb_masked_boxcar_smoother_core;

    localparam int WIN_MAX    = 31;
    localparam int SERIES_MAX = 4096;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE     = 150;

    typedef struct packed {
        logic [15:0] smoothed;
        logic        status;
        logic        last;
    } smooth_res_t;

    typedef enum int {ROW_CFG, ROW_EXP, ROW_NONE, ROW_PRED} row_kind_t;

    // ROW_CFG: a=window, b=ramp, c=series, d=honour
    // ROW_EXP: a=sample, b=good, c=smoothed, d=status, e=last
    typedef struct {
        row_kind_t kind;
        int a, b, c, d, e;
    } row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [15:0]                     s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [15:0]                     m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_wr_en;
    logic [mbs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mbs_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    masked_boxcar_smoother_core u_dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // shadow registers and smoother state
    int unsigned reg_win, reg_ramp, reg_series, reg_honour;
    logic [15:0] win_buf [WIN_MAX];
    int unsigned rx_count, tx_count;
    int unsigned lat_n, lat_w, lat_tail;
    bit          lat_ramp, lat_err;

    smooth_res_t smoothed_q[$];
    smooth_res_t step_res[$];
    int          errors;
    int          items_sent;
    int          burst_left;
    int          hold_cnt;
    bit          hold_req;
    int          idle_cycles;

    function automatic logic [15:0] window_mean(int unsigned pos, int unsigned newest);
        longint unsigned total;
        int unsigned     wsum, age, s, wt;
        int              p;
        total = 0;
        wsum  = 0;
        for (int j = 0; j < lat_w; j++) begin
            p = int'(pos) + j - int'(lat_tail);
            if (p < 0 || p > int'(newest) || p >= int'(lat_n)) continue;
            age = newest - p;
            if (age >= WIN_MAX) continue;
            s = win_buf[age];
            if (s == 0) continue;
            if (lat_ramp) wt = (j < lat_tail) ? j + 1 : lat_w - j;
            else wt = 1;
            total += longint'(s) * wt;
            wsum  += wt;
        end
        if (wsum == 0) return 16'd0;
        return 16'(total / wsum);
    endfunction

    // advances the model by one sample; results land in step_res
    task automatic smoother_step(logic [15:0] sample, logic good);
        int unsigned k;
        bit          last_in;
        smooth_res_t r;
        step_res.delete();
        if (rx_count == 0) begin
            lat_n = reg_series;
            if (lat_n == 0) lat_n = 1;
            if (lat_n > SERIES_MAX) lat_n = SERIES_MAX;
            lat_err = reg_win > lat_n / 2;
            lat_w = reg_win;
            if (lat_w % 2 == 0) lat_w++;
            if (lat_w > WIN_MAX) lat_w = WIN_MAX;
            lat_tail = lat_w / 2;
            lat_ramp = reg_ramp != 0;
        end
        for (int i = WIN_MAX - 1; i > 0; i--) win_buf[i] = win_buf[i-1];
        win_buf[0] = (good || reg_honour == 0) ? sample : 16'd0;
        k = rx_count;
        rx_count++;
        last_in = rx_count >= lat_n;
        if (lat_err) begin
            if (last_in) begin
                r = '{16'd0, 1'b1, 1'b1};
                step_res.push_back(r);
            end
        end else if (last_in || k >= lat_tail) begin
            do begin
                r.smoothed = window_mean(tx_count, k);
                r.status   = 1'b0;
                r.last     = tx_count == lat_n - 1;
                step_res.push_back(r);
                tx_count++;
            end while (last_in && tx_count < lat_n);
        end
        if (last_in) begin
            rx_count = 0;
            tx_count = 0;
        end
    endtask

    task automatic cfg_write(mbs_pkg::cfg_index_t idx, int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= mbs_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
    endtask

    // waits for every result, lets the block go quiet, then reprograms it
    task automatic program_series(int unsigned w, int unsigned ramp, int unsigned n,
                                  int unsigned honour);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (smoothed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_write(mbs_pkg::CFG_WINDOW, w);
        cfg_write(mbs_pkg::CFG_RAMP, ramp);
        cfg_write(mbs_pkg::CFG_SERIES, n);
        cfg_write(mbs_pkg::CFG_HONOR, honour);
        cfg_wr_en <= 1'b0;
        reg_win    = w & 5'h1f;
        reg_ramp   = ramp & 1;
        reg_series = n & 13'h1fff;
        reg_honour = honour & 1;
    endtask

    // returns once the transfer has happened; the model is advanced there
    task automatic send_sample(logic [15:0] sample, logic good);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= good;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        smoother_step(sample, good);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1:    return 16'd0;
            2:       return 16'hffff;
            3:       return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_series(int unsigned w, int unsigned ramp, int unsigned n,
                                 int unsigned honour);
        int unsigned cnt;
        program_series(w, ramp, n, honour);
        cnt = (n == 0) ? 1 : (n > SERIES_MAX ? SERIES_MAX : n);
        for (int i = 0; i < cnt; i++) begin
            send_sample(rand_sample(), $urandom_range(0, 4) != 0);
            foreach (step_res[j]) smoothed_q.push_back(step_res[j]);
        end
    endtask

    row_t dir_rows[] = '{
        '{ROW_CFG,  1, 0, 12, 1, 0},
        '{ROW_EXP,  65535, 1, 65535, 0, 0},
        '{ROW_EXP,  0, 1, 0, 0, 0},
        '{ROW_EXP,  1, 1, 1, 0, 0},
        '{ROW_EXP,  65535, 0, 0, 0, 0},
        '{ROW_EXP,  32768, 1, 32768, 0, 0},
        '{ROW_EXP,  43690, 1, 43690, 0, 0},
        '{ROW_EXP,  21845, 0, 0, 0, 0},
        '{ROW_EXP,  255, 1, 255, 0, 0},
        '{ROW_EXP,  256, 1, 256, 0, 0},
        '{ROW_EXP,  1000, 0, 0, 0, 0},
        '{ROW_EXP,  7, 1, 7, 0, 0},
        '{ROW_EXP,  9, 1, 9, 0, 1},
        // zero series length taken as one, zero window, flags ignored
        '{ROW_CFG,  0, 1, 0, 0, 0},
        '{ROW_EXP,  500, 0, 500, 0, 1},
        // window longer than half the series: one error result at the end
        '{ROW_CFG,  5, 0, 4, 1, 0},
        '{ROW_NONE, 100, 1, 0, 0, 0},
        '{ROW_NONE, 200, 1, 0, 0, 0},
        '{ROW_NONE, 300, 0, 0, 0, 0},
        '{ROW_EXP,  400, 1, 0, 1, 1},
        // even window widened, ramp weights
        '{ROW_CFG,  2, 1, 5, 1, 0},
        '{ROW_PRED, 1200, 1, 0, 0, 0},
        '{ROW_PRED, 0, 1, 0, 0, 0},
        '{ROW_PRED, 65535, 1, 0, 0, 0},
        '{ROW_PRED, 3000, 0, 0, 0, 0},
        '{ROW_PRED, 4500, 1, 0, 0, 0}
    };

    // result checker
    always @(posedge aclk) begin
        smooth_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (smoothed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: smoothed=%0d status=%0b last=%0b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = smoothed_q.pop_front();
                if (m_tdata !== want.smoothed || m_tuser !== want.status ||
                    m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 want.smoothed, want.status, want.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // receiver: segments of always-ready, fixed pattern or random,
    // plus one long hold-off on request
    int rx_phase;
    int rx_mode;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_phase = 0;
            rx_mode  = 0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            rx_phase++;
            if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= (rx_phase % 13) < 8;
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        row_t r;
        errors      = 0;
        items_sent  = 0;
        burst_left  = 0;
        hold_cnt    = 0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        reg_win     = 5;
        reg_ramp    = 0;
        reg_series  = 365;
        reg_honour  = 1;
        rx_count    = 0;
        tx_count    = 0;
        lat_n = 1; lat_w = 1; lat_tail = 0; lat_ramp = 0; lat_err = 0;
        foreach (win_buf[i]) win_buf[i] = '0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= mbs_pkg::CFG_WINDOW;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG) begin
                program_series(r.a, r.b, r.c, r.d);
            end else begin
                send_sample(16'(r.a), r.b[0]);
                if (r.kind == ROW_EXP)
                    smoothed_q.push_back('{16'(r.c), r.d[0], r.e[0]});
                else if (r.kind == ROW_PRED)
                    foreach (step_res[j]) smoothed_q.push_back(step_res[j]);
            end
        end

        // input must back up behind the stalled output here
        hold_req = 1'b1;
        random_series(31, 1, 62, 1);
        random_series(2, 1, 9, 1);
        random_series(4, 0, 9, 0);
        random_series(7, 1, 15, 0);
        random_series(1, 0, 1, 1);
        random_series(0, 1, 3, 0);
        while (items_sent < 170) begin
            if ($urandom_range(0, 5) == 0)
                random_series($urandom_range(3, 31), $urandom_range(0, 1),
                              $urandom_range(1, 8), $urandom_range(0, 1));
            else
                random_series($urandom_range(0, 9), $urandom_range(0, 1),
                              $urandom_range(18, 40), $urandom_range(0, 1));
        end
        s_tvalid <= 1'b0;

        while (smoothed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && smoothed_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
